// File: rtl/core/assert_macros.svh
// assertion helpers for the checked alu core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CIA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CIA_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CIA_ASSERT(name, clk, rst_n, prop)
`define CIA_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

// File: rtl/core/cia_pkg.sv
package cia_pkg;

  localparam int DataWidth  = 32;
  localparam int FieldWidth = 32;
  localparam int WideWidth  = 2 * FieldWidth;

  localparam logic signed [WideWidth-1:0] IntMax =
    (WideWidth'(64'sd1) <<< (DataWidth - 1)) - WideWidth'(64'sd1);
  localparam logic signed [WideWidth-1:0] IntMin =
    -(WideWidth'(64'sd1) <<< (DataWidth - 1));

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_POW = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_POS_OVF = 2'd1,
    ST_NEG_OVF = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    STEP_FETCH    = 3'd0,
    STEP_ADD      = 3'd1,
    STEP_SUB      = 3'd2,
    STEP_MUL      = 3'd3,
    STEP_POW_INIT = 3'd4,
    STEP_POW_LOOP = 3'd5,
    STEP_FINISH   = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    W_ADD    = 3'd0,
    W_SUB    = 3'd1,
    W_MUL_AB = 3'd2,
    W_MUL_WA = 3'd3,
    W_SEED   = 3'd4
  } wop_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_LOAD = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_DISPATCH = 3'd1,
    C_SPECIAL  = 3'd2,
    C_MORE     = 3'd3,
    C_BUSY     = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    GATE_ALWAYS    = 2'd0,
    GATE_TAKEN     = 2'd1,
    GATE_NOT_TAKEN = 2'd2
  } gate_e;

  typedef struct packed {
    wop_e    wop;
    logic    wen;
    cnt_op_e cnt_op;
    gate_e   gate;
    cond_e   cond;
    step_e   jump_to;
    step_e   next_to;
    logic    out_load;
    logic    in_ready;
  } ucode_t;

  typedef struct packed {
    wop_e    wop;
    logic    w_en;
    cnt_op_e cnt_op;
    logic    out_en;
    logic    load_in;
  } dp_ctl_t;

  typedef struct packed {
    logic special;
    logic more;
    logic busy;
  } dp_flags_t;

  function automatic ucode_t ucode(step_e step);
    ucode_t uw;
    uw = '{wop: W_ADD, wen: 1'b0, cnt_op: CNT_HOLD, gate: GATE_ALWAYS, cond: C_NONE,
           jump_to: STEP_FETCH, next_to: STEP_FETCH, out_load: 1'b0, in_ready: 1'b0};
    unique case (step)
      STEP_FETCH: begin
        uw.cond     = C_DISPATCH;
        uw.in_ready = 1'b1;
      end
      STEP_ADD: begin
        uw.wop     = W_ADD;
        uw.wen     = 1'b1;
        uw.next_to = STEP_FINISH;
      end
      STEP_SUB: begin
        uw.wop     = W_SUB;
        uw.wen     = 1'b1;
        uw.next_to = STEP_FINISH;
      end
      STEP_MUL: begin
        uw.wop     = W_MUL_AB;
        uw.wen     = 1'b1;
        uw.next_to = STEP_FINISH;
      end
      STEP_POW_INIT: begin
        uw.wop     = W_SEED;
        uw.wen     = 1'b1;
        uw.cnt_op  = CNT_LOAD;
        uw.cond    = C_SPECIAL;
        uw.jump_to = STEP_FINISH;
        uw.next_to = STEP_POW_LOOP;
      end
      STEP_POW_LOOP: begin
        uw.wop     = W_MUL_WA;
        uw.wen     = 1'b1;
        uw.cnt_op  = CNT_DEC;
        uw.gate    = GATE_TAKEN;
        uw.cond    = C_MORE;
        uw.jump_to = STEP_POW_LOOP;
        uw.next_to = STEP_FINISH;
      end
      STEP_FINISH: begin
        uw.gate     = GATE_NOT_TAKEN;
        uw.cond     = C_BUSY;
        uw.jump_to  = STEP_FINISH;
        uw.next_to  = STEP_FETCH;
        uw.out_load = 1'b1;
      end
      default: begin
        uw.next_to = STEP_FETCH;
      end
    endcase
    return uw;
  endfunction

endpackage

// File: rtl/core/checked_int32_alu_unit.sv
// channel   dir  tdata                               tuser
// s_axis    in   [31:0] operand_a, [63:32] operand_b  [1:0] action
// m_axis    out  [31:0] result_value                 [1:0] status
//
// add, subtract, multiply: operand registers, then work register, then result register
// power: exponent 0 or base 0, 1, -1 goes from seed to finish, else the power loop runs
// (one shared 32x32 multiplier, one multiply per cycle in the power loop)
// input is taken only at fetch, so a new item waits until the current one has left finish
// finish stalls while the output register holds a result not yet transferred
// rst_ni clears the sequencer and the output valid flag

module checked_int32_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  cia_pkg::dp_ctl_t   ctl;
  cia_pkg::dp_flags_t flags;
  logic signed [31:0] operand_a, operand_b, result_value;

  assign operand_a = s_axis_tdata[31:0];
  assign operand_b = s_axis_tdata[63:32];

  cia_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .flags_i    (flags),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl)
  );

  cia_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .out_ready_i    (m_axis_tready),
    .flags_o        (flags),
    .out_valid_o    (m_axis_tvalid),
    .result_value_o (result_value),
    .status_o       (m_axis_tuser)
  );

  assign m_axis_tdata = result_value;

endmodule

// File: rtl/core/cia_sequencer.sv
`include "assert_macros.svh"

module cia_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          action_i,
  input  cia_pkg::dp_flags_t  flags_i,
  output logic                in_ready_o,
  output cia_pkg::dp_ctl_t    ctl_o
);

  cia_pkg::step_e  step_q, step_d;
  cia_pkg::ucode_t uw;
  cia_pkg::step_e  target;
  logic            accept;
  logic            taken;
  logic            en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= cia_pkg::STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    uw     = cia_pkg::ucode(step_q);
    accept = in_valid_i & uw.in_ready;
    unique case (uw.cond)
      cia_pkg::C_NONE:     taken = 1'b0;
      cia_pkg::C_DISPATCH: taken = accept;
      cia_pkg::C_SPECIAL:  taken = flags_i.special;
      cia_pkg::C_MORE:     taken = flags_i.more;
      cia_pkg::C_BUSY:     taken = flags_i.busy;
      default:             taken = 1'b0;
    endcase
    if (uw.cond == cia_pkg::C_DISPATCH) begin
      target = cia_pkg::step_e'(3'(cia_pkg::STEP_ADD) + {1'b0, action_i});
    end else begin
      target = uw.jump_to;
    end
    step_d = taken ? target : uw.next_to;
    unique case (uw.gate)
      cia_pkg::GATE_ALWAYS:    en = 1'b1;
      cia_pkg::GATE_TAKEN:     en = taken;
      cia_pkg::GATE_NOT_TAKEN: en = ~taken;
      default:                 en = 1'b0;
    endcase
    ctl_o.wop     = uw.wop;
    ctl_o.w_en    = uw.wen & en;
    ctl_o.cnt_op  = en ? uw.cnt_op : cia_pkg::CNT_HOLD;
    ctl_o.out_en  = uw.out_load & en;
    ctl_o.load_in = accept;
    in_ready_o    = uw.in_ready;
  end

  `CIA_ASSERT(a_accept_leaves_fetch, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> (step_q != cia_pkg::STEP_FETCH))
  `CIA_ASSERT(a_finish_returns, clk_i, rst_ni,
    (step_q == cia_pkg::STEP_FINISH && !flags_i.busy) |=> (step_q == cia_pkg::STEP_FETCH))

endmodule

// File: rtl/core/cia_datapath.sv
`include "assert_macros.svh"

module cia_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cia_pkg::dp_ctl_t                     ctl_i,
  input  logic signed [cia_pkg::FieldWidth-1:0] operand_a_i,
  input  logic signed [cia_pkg::FieldWidth-1:0] operand_b_i,
  input  logic                                 out_ready_i,
  output cia_pkg::dp_flags_t                   flags_o,
  output logic                                 out_valid_o,
  output logic signed [cia_pkg::FieldWidth-1:0] result_value_o,
  output logic [1:0]                           status_o
);

  localparam int FW = cia_pkg::FieldWidth;
  localparam int WW = cia_pkg::WideWidth;

  logic signed [FW-1:0] a_q, b_q;
  logic signed [WW-1:0] w_q, w_d;
  logic [FW-1:0]        cnt_q, cnt_d;
  logic                 out_valid_q;
  logic signed [FW-1:0] value_q, value_d;
  logic [1:0]           status_q, status_d;

  logic signed [WW-1:0] a_ext, b_ext;
  logic signed [FW-1:0] w_lo, mul_x;
  logic signed [WW-1:0] product;
  logic signed [WW-1:0] seed;
  logic                 in_range;
  logic                 e_zero, a_one, a_zero, a_mone;

  always_comb begin
    a_ext   = {{FW{a_q[FW-1]}}, a_q};
    b_ext   = {{FW{b_q[FW-1]}}, b_q};
    w_lo    = w_q[FW-1:0];
    mul_x   = (ctl_i.wop == cia_pkg::W_MUL_WA) ? w_lo : b_q;
    product = mul_x * a_q;

    e_zero  = (b_q == '0);
    a_one   = (a_q == FW'(1));
    a_zero  = (a_q == '0);
    a_mone  = (a_q == '1);
    priority if (e_zero || a_one) begin
      seed = WW'(1);
    end else if (a_zero) begin
      seed = '0;
    end else if (a_mone) begin
      seed = b_q[0] ? '1 : WW'(1);
    end else begin
      seed = a_ext;
    end

    in_range = (w_q <= cia_pkg::IntMax) && (w_q >= cia_pkg::IntMin);

    flags_o.special = e_zero | a_one | a_zero | a_mone;
    flags_o.more    = (cnt_q != '0) && in_range;
    flags_o.busy    = out_valid_q & ~out_ready_i;

    unique case (ctl_i.wop)
      cia_pkg::W_ADD:    w_d = a_ext + b_ext;
      cia_pkg::W_SUB:    w_d = a_ext - b_ext;
      cia_pkg::W_MUL_AB: w_d = product;
      cia_pkg::W_MUL_WA: w_d = product;
      cia_pkg::W_SEED:   w_d = seed;
      default:           w_d = w_q;
    endcase

    unique case (ctl_i.cnt_op)
      cia_pkg::CNT_HOLD: cnt_d = cnt_q;
      cia_pkg::CNT_LOAD: cnt_d = b_q - FW'(1);
      cia_pkg::CNT_DEC:  cnt_d = cnt_q - FW'(1);
      default:           cnt_d = cnt_q;
    endcase

    if (in_range) begin
      value_d  = w_lo;
      status_d = cia_pkg::ST_OK;
    end else begin
      value_d  = '0;
      status_d = w_q[WW-1] ? cia_pkg::ST_NEG_OVF : cia_pkg::ST_POS_OVF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
    end
    if (ctl_i.w_en) begin
      w_q <= w_d;
    end
    cnt_q <= cnt_d;
    if (ctl_i.out_en) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = value_q;
  assign status_o       = status_q;

  `CIA_ASSERT(a_loop_counts_down, clk_i, rst_ni,
    (ctl_i.cnt_op == cia_pkg::CNT_DEC) |=> (cnt_q == $past(cnt_q) - FW'(1)))
  `CIA_ASSERT(a_overflow_zero_value, clk_i, rst_ni,
    (out_valid_q && status_q != cia_pkg::ST_OK) |-> (value_q == '0))
  `CIA_ASSERT_NEVER(a_load_over_pending, clk_i, rst_ni,
    ctl_i.out_en && out_valid_q && !out_ready_i)

endmodule
